// ----- rtl/core/eckf_pkg.sv -----
// ----------------------------------------------------------------------------
// eckf_pkg
// Shared widths, register codes, reset values and helpers for the ellipse
// color key filter.
// ----------------------------------------------------------------------------
package eckf_pkg;

  // Pixel channel width and the fixed 8-bit width of a focus coordinate.
  localparam int COLOR_BITS = 8;
  localparam int FOCUS_W    = 8;

  // Datapath widths and the 10-bit limit width; the rest are derived so that every product and sum stays exact.
  localparam int D_W     = (COLOR_BITS > FOCUS_W) ? COLOR_BITS : FOCUS_W;
  localparam int SQ_W    = 2 * D_W;
  localparam int P_W     = SQ_W + 1;
  localparam int LIMIT_W = 10;
  localparam int LSQ_W   = 2 * LIMIT_W;
  localparam int T_W     = ((LSQ_W > P_W + 1) ? LSQ_W : (P_W + 1)) + 1;
  localparam int TM_W    = T_W - 1;
  localparam int PQ_W    = 2 * P_W + 2;
  localparam int TT_W    = 2 * TM_W;
  localparam int CMP_W   = (PQ_W > TT_W) ? PQ_W : TT_W;

  // Register and stream widths.
  localparam int FOCI_W   = 4 * FOCUS_W;
  localparam int KEY_W    = 24;
  localparam int PIX_W    = 3 * COLOR_BITS;
  localparam int TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int APB_DW   = 32;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;

  // Pipeline depth: four arithmetic stages plus the output register.
  localparam int STAGES   = 5;

  typedef enum logic [IDX_W-1:0] {
    REG_A_FOCI  = 3'd0,
    REG_A_LIMIT = 3'd1,
    REG_B_FOCI  = 3'd2,
    REG_B_LIMIT = 3'd3,
    REG_C_FOCI  = 3'd4,
    REG_C_LIMIT = 3'd5,
    REG_KEY     = 3'd6
  } reg_idx_e;

  localparam logic [FOCI_W-1:0]  A_FOCI_RST  = 32'hC3C8_2328;
  localparam logic [LIMIT_W-1:0] A_LIMIT_RST = 10'd228;
  localparam logic [FOCI_W-1:0]  B_FOCI_RST  = 32'hC3CD_232D;
  localparam logic [LIMIT_W-1:0] B_LIMIT_RST = 10'd229;
  localparam logic [FOCI_W-1:0]  C_FOCI_RST  = 32'hC3B4_2314;
  localparam logic [LIMIT_W-1:0] C_LIMIT_RST = 10'd228;
  localparam logic [KEY_W-1:0]   KEY_RST     = 24'h40FF80;

  // Stage enables and valid bits, handed from the flow control to the datapath.
  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } pipe_ctl_t;

  function automatic logic [D_W-1:0] abs_diff(input logic [D_W-1:0] a,
                                               input logic [D_W-1:0] b);
    logic [D_W-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

// ----- rtl/core/ellipse_color_key_filter_top.sv -----
// ----------------------------------------------------------------------------
// ellipse_color_key_filter_top
// Color keying of a pixel stream against three ellipses in channel planes.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock, provided the output side is ready,
// and returns each pixel in order. A pixel is kept
// when, for at least one of the three ellipses (ch0/ch1, ch0/ch2, ch2/ch1),
// the sum of its distances to the two foci is strictly greater than the
// limit; otherwise the programmed key color goes out instead and tuser is
// low. The test is exact in integer arithmetic: the square root is avoided
// by comparing 4*P*Q against (L*L - P - Q) squared. The pipeline is four
// arithmetic stages (differences, squares, limit subtraction, products)
// followed by the output register, where the three decisions are combined.
// Throughput is one pixel per cycle; every stage loads whenever it is empty
// or its beat moves on, so empty slots close up while the output is stalled
// and the input keeps accepting beats until all five stages are occupied.
// Registers sit on an APB port at byte offsets 4*i and should be written
// only while no pixel is in flight.
// ----------------------------------------------------------------------------
module ellipse_color_key_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Pixel input. tdata: chan0_in [7:0], chan1_in [15:8], chan2_in [23:16].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [eckf_pkg::TDATA_W-1:0]  s_axis_tdata,

  // Pixel output. tdata: chan0_out [7:0], chan1_out [15:8], chan2_out [23:16].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [eckf_pkg::TDATA_W-1:0]  m_axis_tdata,
  // tuser: passed [0].
  output logic                          m_axis_tuser,

  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eckf_pkg::ADDR_W-1:0]   paddr,
  input  logic [eckf_pkg::APB_DW-1:0]   pwdata,
  output logic [eckf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int CB = eckf_pkg::COLOR_BITS;
  localparam int LAST = eckf_pkg::STAGES - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [eckf_pkg::FOCI_W-1:0]  a_foci_q, b_foci_q, c_foci_q;
  logic [eckf_pkg::LIMIT_W-1:0] a_limit_q, b_limit_q, c_limit_q;
  logic [eckf_pkg::KEY_W-1:0]   key_q;

  logic                     cfg_wr;
  eckf_pkg::reg_idx_e       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = eckf_pkg::reg_idx_e'(paddr[eckf_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_foci_q  <= eckf_pkg::A_FOCI_RST;
      a_limit_q <= eckf_pkg::A_LIMIT_RST;
      b_foci_q  <= eckf_pkg::B_FOCI_RST;
      b_limit_q <= eckf_pkg::B_LIMIT_RST;
      c_foci_q  <= eckf_pkg::C_FOCI_RST;
      c_limit_q <= eckf_pkg::C_LIMIT_RST;
      key_q     <= eckf_pkg::KEY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        eckf_pkg::REG_A_FOCI:  a_foci_q  <= pwdata[eckf_pkg::FOCI_W-1:0];
        eckf_pkg::REG_A_LIMIT: a_limit_q <= pwdata[eckf_pkg::LIMIT_W-1:0];
        eckf_pkg::REG_B_FOCI:  b_foci_q  <= pwdata[eckf_pkg::FOCI_W-1:0];
        eckf_pkg::REG_B_LIMIT: b_limit_q <= pwdata[eckf_pkg::LIMIT_W-1:0];
        eckf_pkg::REG_C_FOCI:  c_foci_q  <= pwdata[eckf_pkg::FOCI_W-1:0];
        eckf_pkg::REG_C_LIMIT: c_limit_q <= pwdata[eckf_pkg::LIMIT_W-1:0];
        eckf_pkg::REG_KEY:     key_q     <= pwdata[eckf_pkg::KEY_W-1:0];
        default: ;  // Offsets past the register list are ignored.
      endcase
    end
  end

  // Read data is combinational from the register file; unused offsets read 0.
  always_comb begin
    case (cfg_idx)
      eckf_pkg::REG_A_FOCI:  prdata = eckf_pkg::APB_DW'(a_foci_q);
      eckf_pkg::REG_A_LIMIT: prdata = eckf_pkg::APB_DW'(a_limit_q);
      eckf_pkg::REG_B_FOCI:  prdata = eckf_pkg::APB_DW'(b_foci_q);
      eckf_pkg::REG_B_LIMIT: prdata = eckf_pkg::APB_DW'(b_limit_q);
      eckf_pkg::REG_C_FOCI:  prdata = eckf_pkg::APB_DW'(c_foci_q);
      eckf_pkg::REG_C_LIMIT: prdata = eckf_pkg::APB_DW'(c_limit_q);
      eckf_pkg::REG_KEY:     prdata = eckf_pkg::APB_DW'(key_q);
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  eckf_pkg::pipe_ctl_t ctl;

  eckf_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  assign s_axis_tready = ctl.en[0];
  assign m_axis_tvalid = ctl.vld[LAST];

  // --------------------------------------------------------------------------
  // Datapath: three ellipse tests in parallel, pixel carried alongside.
  // --------------------------------------------------------------------------
  logic [CB-1:0] c0_in, c1_in, c2_in;
  logic          out_a, out_b, out_c;

  assign c0_in = s_axis_tdata[0*CB +: CB];
  assign c1_in = s_axis_tdata[1*CB +: CB];
  assign c2_in = s_axis_tdata[2*CB +: CB];

  eckf_ellipse u_ell_a (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .u_i       (c0_in),
    .v_i       (c1_in),
    .foci_i    (a_foci_q),
    .limit_i   (a_limit_q),
    .outside_o (out_a)
  );

  eckf_ellipse u_ell_b (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .u_i       (c0_in),
    .v_i       (c2_in),
    .foci_i    (b_foci_q),
    .limit_i   (b_limit_q),
    .outside_o (out_b)
  );

  eckf_ellipse u_ell_c (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .u_i       (c2_in),
    .v_i       (c1_in),
    .foci_i    (c_foci_q),
    .limit_i   (c_limit_q),
    .outside_o (out_c)
  );

  // The original pixel follows the arithmetic stages in a delay line.
  logic [eckf_pkg::PIX_W-1:0] pix_q [LAST];
  logic [eckf_pkg::PIX_W-1:0] key_pix;
  logic [eckf_pkg::PIX_W-1:0] out_pix_q;
  logic                       out_pass_q;
  logic                       pass_d;

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      pix_q[0] <= {c2_in, c1_in, c0_in};
    end
    for (int k = 1; k < LAST; k++) begin
      if (ctl.en[k]) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  // Each key color byte is cut or widened to the channel width.
  assign key_pix = {CB'(key_q[23:16]), CB'(key_q[15:8]), CB'(key_q[7:0])};
  assign pass_d  = out_a || out_b || out_c;

  always_ff @(posedge clk_i) begin
    if (ctl.en[LAST]) begin
      out_pass_q <= pass_d;
      out_pix_q  <= pass_d ? pix_q[LAST-1] : key_pix;
    end
  end

  assign m_axis_tdata = eckf_pkg::TDATA_W'(out_pix_q);
  assign m_axis_tuser = out_pass_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // With the output register empty the whole enable chain is open.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled although the output register is empty");

  // An accepted beat occupies the first stage on the next cycle.
  a_accept_fills_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ctl.vld[0])
    else $error("accepted beat did not enter the first stage");

  // A full pipeline with a stalled output must push back on the input.
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&ctl.vld) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while every stage is occupied and stalled");

  // A stalled result keeps its decision until it is taken.
  a_stall_holds_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_pass_q))
    else $error("pending result changed while stalled");

endmodule

// ----- rtl/core/eckf_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// eckf_pipe_ctrl
// Valid bits and per-stage load enables for the filter pipeline.
// ----------------------------------------------------------------------------
module eckf_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output eckf_pkg::pipe_ctl_t  ctl_o
);

  logic [eckf_pkg::STAGES-1:0] vld_q;
  logic [eckf_pkg::STAGES-1:0] vld_d;
  logic [eckf_pkg::STAGES-1:0] en;

  // A stage loads when it is empty or its content moves on this cycle, so
  // bubbles close up while the output waits.
  always_comb begin
    en[eckf_pkg::STAGES-1] = !vld_q[eckf_pkg::STAGES-1] || out_ready_i;
    for (int k = eckf_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < eckf_pkg::STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

endmodule

// ----- rtl/core/eckf_ellipse.sv -----
// ----------------------------------------------------------------------------
// eckf_ellipse
// Four-stage exact test of one ellipse: is the distance sum from a point to
// the two foci strictly greater than the limit?
// ----------------------------------------------------------------------------
module eckf_ellipse (
  input  logic                                  clk_i,
  input  eckf_pkg::pipe_ctl_t                   ctl_i,
  input  logic [eckf_pkg::COLOR_BITS-1:0]       u_i,
  input  logic [eckf_pkg::COLOR_BITS-1:0]       v_i,
  input  logic [eckf_pkg::FOCI_W-1:0]           foci_i,
  input  logic [eckf_pkg::LIMIT_W-1:0]          limit_i,
  output logic                                  outside_o
);

  localparam int DW = eckf_pkg::D_W;
  localparam int FW = eckf_pkg::FOCUS_W;

  // Stage 1: absolute coordinate differences to both foci.
  logic [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  // Stage 2: squared distances.
  logic [eckf_pkg::P_W-1:0] p2_q, q2_q;
  // Stage 3: T = L*L - P - Q.
  logic [eckf_pkg::P_W-1:0] p3_q, q3_q;
  logic signed [eckf_pkg::T_W-1:0] t3_q;
  // Stage 4: products.
  logic                        neg4_q;
  logic [eckf_pkg::PQ_W-1:0]   pq4_q;
  logic [eckf_pkg::TT_W-1:0]   tt4_q;

  logic [DW-1:0] u_ext, v_ext;
  logic [eckf_pkg::SQ_W-1:0] sq_u1, sq_v1, sq_u2, sq_v2;
  logic [eckf_pkg::LSQ_W-1:0] lsq;
  logic signed [eckf_pkg::T_W-1:0] t_d;
  logic [eckf_pkg::TM_W-1:0] t_mag;

  assign u_ext = DW'(u_i);
  assign v_ext = DW'(v_i);

  assign sq_u1 = du1_q * du1_q;
  assign sq_v1 = dv1_q * dv1_q;
  assign sq_u2 = du2_q * du2_q;
  assign sq_v2 = dv2_q * dv2_q;

  assign lsq = limit_i * limit_i;
  assign t_d = $signed({1'b0, eckf_pkg::TM_W'(lsq)})
             - $signed({1'b0, eckf_pkg::TM_W'(p2_q)})
             - $signed({1'b0, eckf_pkg::TM_W'(q2_q)});

  assign t_mag = t3_q[eckf_pkg::TM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      du1_q <= eckf_pkg::abs_diff(u_ext, DW'(foci_i[0*FW +: FW]));
      dv1_q <= eckf_pkg::abs_diff(v_ext, DW'(foci_i[1*FW +: FW]));
      du2_q <= eckf_pkg::abs_diff(u_ext, DW'(foci_i[2*FW +: FW]));
      dv2_q <= eckf_pkg::abs_diff(v_ext, DW'(foci_i[3*FW +: FW]));
    end
    if (ctl_i.en[1]) begin
      p2_q <= eckf_pkg::P_W'(sq_u1) + eckf_pkg::P_W'(sq_v1);
      q2_q <= eckf_pkg::P_W'(sq_u2) + eckf_pkg::P_W'(sq_v2);
    end
    if (ctl_i.en[2]) begin
      p3_q <= p2_q;
      q3_q <= q2_q;
      t3_q <= t_d;
    end
    if (ctl_i.en[3]) begin
      neg4_q <= t3_q[eckf_pkg::T_W-1];
      pq4_q  <= {eckf_pkg::PQ_W'(p3_q * q3_q)} << 2;
      tt4_q  <= t_mag * t_mag;
    end
  end

  // A negative T already means the sum exceeds the limit; otherwise the
  // squared form 4PQ > T*T decides.
  assign outside_o = neg4_q
                  || (eckf_pkg::CMP_W'(pq4_q) > eckf_pkg::CMP_W'(tt4_q));

endmodule
